>>> sv/pfpsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfpsd_pkg
// Shared widths, reset values, register indexes and status codes of the
// prompt fraction histogram block.
// ----------------------------------------------------------------------------
package pfpsd_pkg;

	localparam int TIME_W     = 24;
	localparam int CNT_W      = 13;
	localparam int BIN_OUT_W  = 6;
	localparam int BCNT_W     = 32;
	localparam int STAT_W     = 2;
	localparam int CFG_IDX_W  = 2;

	localparam int NUM_BINS_DEF = 50;
	localparam int MAX_HITS_DEF = 4096;
	localparam int CNT_FIELD_MAX = (1 << CNT_W) - 1;

	typedef logic [STAT_W-1:0] status_t;

	localparam status_t STAT_FILLED    = 2'd0;
	localparam status_t STAT_EMPTY     = 2'd1;
	localparam status_t STAT_ZERO_WIN  = 2'd2;
	localparam status_t STAT_RATIO_ONE = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_PROMPT_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PROMPT_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_END  = 2'd2;

	localparam logic signed [TIME_W-1:0] PROMPT_LOW_RST  = -24'sd320;
	localparam logic signed [TIME_W-1:0] PROMPT_HIGH_RST = 24'sd640;
	localparam logic signed [TIME_W-1:0] WINDOW_END_RST  = 24'sd160000;

endpackage

>>> sv/pfpsd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfpsd_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfpsd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 50,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> sv/prompt_fraction_psd_histogram_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prompt_fraction_psd_histogram_top
// Counts prompt and wide-window hits per event, forms the prompt fraction
// bin and keeps a histogram of it in a RAM.
// ----------------------------------------------------------------------------
// channel   | signals                                   | handshake
// item      | hit_time, hit_valid, end_of_event         | item_valid / item_stall
// result    | prompt_hits, window_hits, bin_index,      | result_valid / result_stall
//           | bin_count, status                         |
// config    | cfg_index, cfg_data                       | cfg_we
//
// a hit request is taken every cycle once the clearing sweep is done; the window counters are plain registers
// an end request starts the bin engine: a multiply, a divide (one quotient bit
// per step), one RAM read and a write-back as the result is loaded; an empty
// event, zero window or prompt >= window goes straight to the result; hits of
// the next event are taken meanwhile, the next end request waits for the engine
// after reset the histogram RAM is swept to zero with the input stalled
// a stalled result holds in the output register and holds the engine
// ----------------------------------------------------------------------------
module prompt_fraction_psd_histogram_top
	import pfpsd_pkg::*;
#(
	parameter int NUM_BINS = NUM_BINS_DEF,
	parameter int MAX_HITS = MAX_HITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [TIME_W-1:0]        cfg_data,
	input  logic                     item_valid,
	output logic                     item_stall,
	input  logic signed [TIME_W-1:0] hit_time,
	input  logic                     hit_valid,
	input  logic                     end_of_event,
	output logic                     result_valid,
	input  logic                     result_stall,
	output logic [CNT_W-1:0]         prompt_hits,
	output logic [CNT_W-1:0]         window_hits,
	output logic [BIN_OUT_W-1:0]     bin_index,
	output logic [BCNT_W-1:0]        bin_count,
	output status_t                  status
);

	localparam int QW   = $clog2(NUM_BINS);
	localparam int NB_W = $clog2(NUM_BINS + 1);
	localparam int PW   = CNT_W + NB_W;
	localparam int SW   = (QW > 1) ? $clog2(QW) : 1;
	localparam logic [CNT_W-1:0] HIT_CAP =
		CNT_W'((MAX_HITS < CNT_FIELD_MAX) ? MAX_HITS : CNT_FIELD_MAX);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_RD   = 3'd3;
	localparam logic [2:0] ST_UPD  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	// configuration
	logic signed [TIME_W-1:0] prompt_low_q, prompt_high_q, window_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prompt_low_q  <= PROMPT_LOW_RST;
			prompt_high_q <= PROMPT_HIGH_RST;
			window_end_q  <= WINDOW_END_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PROMPT_LOW:  prompt_low_q  <= cfg_data;
				REG_PROMPT_HIGH: prompt_high_q <= cfg_data;
				REG_WINDOW_END:  window_end_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// clearing sweep
	logic          clr_busy_q;
	logic [QW-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == QW'(NUM_BINS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// per-event counters
	logic [2:0]       state_q;
	logic [CNT_W-1:0] p_cnt_q, w_cnt_q;
	logic             seen_q;
	logic             item_fire, in_prompt, in_window;
	logic [CNT_W-1:0] p_nxt, w_nxt;
	logic             seen_nxt;

	assign item_stall = clr_busy_q || (end_of_event && (state_q != ST_IDLE));
	assign item_fire  = item_valid && !item_stall;

	assign in_prompt = hit_valid && (hit_time > prompt_low_q) && (hit_time < prompt_high_q);
	assign in_window = hit_valid && (hit_time > prompt_low_q) && (hit_time < window_end_q);
	assign p_nxt     = (in_prompt && (p_cnt_q != HIT_CAP)) ? p_cnt_q + 1'b1 : p_cnt_q;
	assign w_nxt     = (in_window && (w_cnt_q != HIT_CAP)) ? w_cnt_q + 1'b1 : w_cnt_q;
	assign seen_nxt  = seen_q || hit_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_cnt_q <= '0;
			w_cnt_q <= '0;
			seen_q  <= 1'b0;
		end else if (item_fire) begin
			if (end_of_event) begin
				p_cnt_q <= '0;
				w_cnt_q <= '0;
				seen_q  <= 1'b0;
			end else begin
				p_cnt_q <= p_nxt;
				w_cnt_q <= w_nxt;
				seen_q  <= seen_nxt;
			end
		end
	end

	// bin engine
	logic [CNT_W-1:0]  p_q, w_q;
	status_t           stat_q;
	logic [PW-1:0]     rem_q, dsr_q;
	logic [QW-1:0]     quo_q;
	logic [SW-1:0]     step_q;
	logic              div_ge;
	logic [QW-1:0]     quo_nxt;
	logic              load_out;
	logic [BCNT_W-1:0] rd_data, new_cnt;
	logic              ram_we;
	logic [QW-1:0]     ram_waddr;
	logic [BCNT_W-1:0] ram_wdata;

	assign div_ge   = rem_q >= dsr_q;
	assign quo_nxt  = QW'({quo_q, div_ge});
	assign load_out = ((state_q == ST_UPD) || (state_q == ST_OUT))
		&& (!result_valid || !result_stall);
	assign new_cnt  = (rd_data == '1) ? rd_data : rd_data + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (item_fire && end_of_event) begin
						if (!seen_nxt || (w_nxt == '0) || (p_nxt >= w_nxt)) begin
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: state_q <= ST_DIV;
				ST_DIV: begin
					if (step_q == '0) begin
						if ({1'b0, quo_nxt} < (QW + 1)'(NUM_BINS)) begin
							state_q <= ST_RD;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_RD: state_q <= ST_UPD;
				ST_UPD, ST_OUT: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (item_fire && end_of_event) begin
					p_q <= p_nxt;
					w_q <= w_nxt;
					if (!seen_nxt) begin
						stat_q <= STAT_EMPTY;
					end else if (w_nxt == '0) begin
						stat_q <= STAT_ZERO_WIN;
					end else if (p_nxt >= w_nxt) begin
						stat_q <= STAT_RATIO_ONE;
					end else begin
						stat_q <= STAT_FILLED;
					end
				end
			end
			ST_MUL: begin
				rem_q  <= PW'(NUM_BINS) * PW'(p_q);
				dsr_q  <= PW'(w_q) << (QW - 1);
				quo_q  <= '0;
				step_q <= SW'(QW - 1);
			end
			ST_DIV: begin
				if (div_ge) begin
					rem_q <= rem_q - dsr_q;
				end
				dsr_q  <= dsr_q >> 1;
				quo_q  <= quo_nxt;
				step_q <= step_q - 1'b1;
				// quotient past the last bin cannot occur when prompt < window
				if ((step_q == '0) && ({1'b0, quo_nxt} >= (QW + 1)'(NUM_BINS))) begin
					stat_q <= STAT_RATIO_ONE;
				end
			end
			default: ;
		endcase
	end

	assign ram_we    = clr_busy_q || ((state_q == ST_UPD) && load_out);
	assign ram_waddr = clr_busy_q ? clr_addr_q : quo_q;
	assign ram_wdata = clr_busy_q ? '0 : new_cnt;

	pfpsd_ram #(
		.WIDTH (BCNT_W),
		.DEPTH (NUM_BINS)
	) u_hist_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (state_q == ST_RD),
		.raddr (quo_q),
		.rdata (rd_data)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (load_out) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			prompt_hits <= p_q;
			window_hits <= w_q;
			if (state_q == ST_UPD) begin
				bin_index <= BIN_OUT_W'(quo_q);
				bin_count <= new_cnt;
				status    <= STAT_FILLED;
			end else begin
				bin_index <= '0;
				bin_count <= '0;
				status    <= stat_q;
			end
		end
	end

endmodule

>>> sv/pfpsd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfpsd_checker
// Port-level checks on the result channel of the prompt fraction histogram.
// ----------------------------------------------------------------------------
module pfpsd_checker
	import pfpsd_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 result_valid,
	input logic                 result_stall,
	input logic [CNT_W-1:0]     prompt_hits,
	input logic [CNT_W-1:0]     window_hits,
	input logic [BIN_OUT_W-1:0] bin_index,
	input logic [BCNT_W-1:0]    bin_count,
	input status_t              status
);

	// a stalled request stays up
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	// a filled bin means the prompt fraction was below one
	a_fill_ratio: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status == STAT_FILLED) |-> (prompt_hits < window_hits))
		else $error("bin filled with prompt not below window");

	// a filled bin was just incremented, so it cannot read zero
	a_fill_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status == STAT_FILLED) |-> (bin_count != '0))
		else $error("filled bin reports zero count");

	// no fill leaves bin and count at zero
	a_nofill_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status != STAT_FILLED) |-> (bin_count == '0) && (bin_index == '0))
		else $error("unfilled result carries a bin");

endmodule

bind prompt_fraction_psd_histogram_top pfpsd_checker u_pfpsd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.prompt_hits  (prompt_hits),
	.window_hits  (window_hits),
	.bin_index    (bin_index),
	.bin_count    (bin_count),
	.status       (status)
);
